/* design/pwm_period_duty_measure_assert.svh */
// Assertion macros shared by the measurement block.
`ifndef PWM_PERIOD_DUTY_MEASURE_ASSERT_SVH
`define PWM_PERIOD_DUTY_MEASURE_ASSERT_SVH

`ifndef SYNTHESIS
`define PDM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PDM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PDM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PDM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* design/pwm_pdm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwm_pdm_pkg;

    localparam int STAMP_BITS = 16;
    localparam int PERIOD_BITS = 17;
    localparam int DUTY_BITS = 7;
    localparam int SHIFT_BITS = 3;

    localparam logic [DUTY_BITS-1:0] PCT_SCALE = 7'd100;
    localparam logic [SHIFT_BITS-1:0] DIV_TOP_SHIFT = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic cap_rise;
        logic cap_fall;
        logic load_meas;
        logic start_div;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/pwm_period_duty_measure.sv */
// PWM period and duty measurement. Each input transaction is one captured edge
// (timer stamp plus polarity). The block waits for rising, falling, then the
// next rising edge; edges of the wrong polarity are dropped. The closing rising
// edge yields one result transaction (period, high time, truncated duty percent,
// zero-period flag) and also opens the next measurement. Differences are taken
// modulo 2^COUNTER_BITS, so one timer wrap between edges is handled. A
// non-closing edge is accepted without stalling the input. A closing edge
// stalls the input after its acceptance until its result is loaded: latch
// the differences, multiply high time by 100, run a restoring divider (one
// quotient bit per cycle), then load the output register, which waits while
// the previous result is still waiting there.
`timescale 1ns / 1ps
`default_nettype none

module pwm_period_duty_measure #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [pwm_pdm_pkg::STAMP_BITS-1:0]  i_edge_stamp,
    input  wire logic                                i_edge_rising,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [pwm_pdm_pkg::PERIOD_BITS-1:0]      o_period_ticks,
    output logic [pwm_pdm_pkg::DUTY_BITS-1:0]        o_duty_percent,
    output logic [pwm_pdm_pkg::STAMP_BITS-1:0]       o_pulse_ticks,
    output logic                                     o_zero_period
);

    pwm_pdm_pkg::t_dp_cmd cmd;
    pwm_pdm_pkg::t_dp_stat stat;

    pwm_pdm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_edge_rising (i_edge_rising),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    pwm_pdm_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_edge_stamp   (i_edge_stamp),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_period_ticks (o_period_ticks),
        .o_duty_percent (o_duty_percent),
        .o_pulse_ticks  (o_pulse_ticks),
        .o_zero_period  (o_zero_period)
    );

endmodule

`default_nettype wire

/* design/pwm_pdm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwm_pdm_dp #(
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic [pwm_pdm_pkg::STAMP_BITS-1:0]    i_edge_stamp,
    input  wire pwm_pdm_pkg::t_dp_cmd                  i_cmd,
    output pwm_pdm_pkg::t_dp_stat                      o_stat,
    output logic [pwm_pdm_pkg::PERIOD_BITS-1:0]        o_period_ticks,
    output logic [pwm_pdm_pkg::DUTY_BITS-1:0]          o_duty_percent,
    output logic [pwm_pdm_pkg::STAMP_BITS-1:0]         o_pulse_ticks,
    output logic                                       o_zero_period
);

    localparam int W = COUNTER_BITS;
    localparam int NUM_BITS = W + pwm_pdm_pkg::DUTY_BITS;

    logic [W-1:0] stamp_w;
    logic [W-1:0] high_w;
    logic [W-1:0] low_w;
    logic [W-1:0] r_rise;
    logic [W-1:0] r_fall;
    logic [W-1:0] r_high;
    logic [W:0] r_period;
    logic [NUM_BITS-1:0] r_num;
    logic [pwm_pdm_pkg::DUTY_BITS-1:0] r_quo;
    logic [pwm_pdm_pkg::SHIFT_BITS-1:0] r_k;
    logic [NUM_BITS:0] divisor_sh;
    logic [NUM_BITS:0] trial;
    logic fits;
    logic period_zero;

    logic [pwm_pdm_pkg::PERIOD_BITS-1:0] r_period_out;
    logic [pwm_pdm_pkg::DUTY_BITS-1:0] r_duty_out;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0] r_pulse_out;
    logic r_zero_out;

    assign stamp_w = W'(i_edge_stamp);
    assign high_w = r_fall - r_rise;
    assign low_w = stamp_w - r_fall;

    assign divisor_sh = (NUM_BITS + 1)'(r_period) << r_k;
    assign trial = {1'b0, r_num} - divisor_sh;
    assign fits = !trial[NUM_BITS];
    assign period_zero = (r_period == '0);

    assign o_stat.div_last = (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise <= '0;
            r_fall <= '0;
        end else begin
            if (i_cmd.cap_rise || i_cmd.load_meas) begin
                r_rise <= stamp_w;
            end
            if (i_cmd.cap_fall) begin
                r_fall <= stamp_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_meas) begin
            r_high <= high_w;
            r_period <= (W + 1)'(high_w) + (W + 1)'(low_w);
        end
        if (i_cmd.start_div) begin
            r_num <= NUM_BITS'(r_high) * NUM_BITS'(pwm_pdm_pkg::PCT_SCALE);
            r_quo <= '0;
            r_k <= pwm_pdm_pkg::DIV_TOP_SHIFT;
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_num <= trial[NUM_BITS-1:0];
            end
            r_quo <= {r_quo[pwm_pdm_pkg::DUTY_BITS-2:0], fits};
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.load_out) begin
            r_period_out <= pwm_pdm_pkg::PERIOD_BITS'(r_period);
            r_pulse_out <= pwm_pdm_pkg::STAMP_BITS'(r_high);
            r_duty_out <= period_zero ? '0 : r_quo;
            r_zero_out <= period_zero;
        end
    end

    assign o_period_ticks = r_period_out;
    assign o_duty_percent = r_duty_out;
    assign o_pulse_ticks = r_pulse_out;
    assign o_zero_period = r_zero_out;

endmodule

`default_nettype wire

/* design/pwm_pdm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_period_duty_measure_assert.svh"

module pwm_pdm_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_edge_rising,
    output logic                       o_stall,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output pwm_pdm_pkg::t_dp_cmd       o_cmd,
    input  wire pwm_pdm_pkg::t_dp_stat i_stat
);

    pwm_pdm_pkg::t_state r_state;
    pwm_pdm_pkg::t_state n_state;
    pwm_pdm_pkg::t_phase r_phase;
    pwm_pdm_pkg::t_phase n_phase;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwm_pdm_pkg::ST_IDLE;
            r_phase <= pwm_pdm_pkg::PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd = '0;
        unique case (r_state)
            pwm_pdm_pkg::ST_IDLE: begin
                if (i_valid) begin
                    unique case (r_phase)
                        pwm_pdm_pkg::PH_HIGH: begin
                            if (!i_edge_rising) begin
                                o_cmd.cap_fall = 1'b1;
                                n_phase = pwm_pdm_pkg::PH_LOW;
                            end
                        end
                        pwm_pdm_pkg::PH_LOW: begin
                            if (i_edge_rising) begin
                                o_cmd.load_meas = 1'b1;
                                n_phase = pwm_pdm_pkg::PH_HIGH;
                                n_state = pwm_pdm_pkg::ST_MUL;
                            end
                        end
                        default: begin
                            if (i_edge_rising) begin
                                o_cmd.cap_rise = 1'b1;
                                n_phase = pwm_pdm_pkg::PH_HIGH;
                            end
                        end
                    endcase
                end
            end
            pwm_pdm_pkg::ST_MUL: begin
                o_cmd.start_div = 1'b1;
                n_state = pwm_pdm_pkg::ST_DIV;
            end
            pwm_pdm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = pwm_pdm_pkg::ST_DONE;
                end
            end
            pwm_pdm_pkg::ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = pwm_pdm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwm_pdm_pkg::ST_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_stall);

    assign o_stall = (r_state != pwm_pdm_pkg::ST_IDLE);
    assign o_valid = r_out_valid;

    `PDM_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out |-> out_free, "result overwritten")
    `PDM_ASSERT(a_mul_then_div, i_clk, i_rst_n, (r_state == pwm_pdm_pkg::ST_MUL) |=> (r_state == pwm_pdm_pkg::ST_DIV), "divide did not follow multiply")
    `PDM_ASSERT(a_busy_phase, i_clk, i_rst_n, (r_state != pwm_pdm_pkg::ST_IDLE) |-> (r_phase == pwm_pdm_pkg::PH_HIGH), "busy without reopened period")
    `PDM_ASSERT_NEVER(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) && ($past(r_state) != pwm_pdm_pkg::ST_DONE), "result without finished divide")

endmodule

`default_nettype wire

/* dv/tb_pwm_period_duty_measure.sv */
`timescale 1ns / 1ps

module tb_pwm_period_duty_measure;

    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [pwm_pdm_pkg::PERIOD_BITS-1:0] period;
        logic [pwm_pdm_pkg::DUTY_BITS-1:0]   duty;
        logic [pwm_pdm_pkg::STAMP_BITS-1:0]  pulse;
        logic                                zero;
    } t_pwm_meas;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0]  i_edge_stamp;
    logic                                i_edge_rising;
    logic                                o_valid;
    logic                                i_stall;
    logic [pwm_pdm_pkg::PERIOD_BITS-1:0] o_period_ticks;
    logic [pwm_pdm_pkg::DUTY_BITS-1:0]   o_duty_percent;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0]  o_pulse_ticks;
    logic                                o_zero_period;

    t_pwm_meas                          meas_q[$];
    pwm_pdm_pkg::t_phase                exp_phase;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0] exp_rise;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0] exp_fall;
    logic [pwm_pdm_pkg::STAMP_BITS-1:0] last_stamp;
    logic                               tx_idle_en;
    logic                               rx_idle_en;
    int                                 fail_cnt;

    pwm_period_duty_measure #(
        .COUNTER_BITS(16)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_edge_stamp(i_edge_stamp),
        .i_edge_rising(i_edge_rising),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_period_ticks(o_period_ticks),
        .o_duty_percent(o_duty_percent),
        .o_pulse_ticks(o_pulse_ticks),
        .o_zero_period(o_zero_period)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Advance the edge tracker; returns 1 when the edge was not ignored.
    function automatic logic track_edge(logic [pwm_pdm_pkg::STAMP_BITS-1:0] stamp,
                                        logic rising);
        logic [pwm_pdm_pkg::STAMP_BITS-1:0]  high_t;
        logic [pwm_pdm_pkg::STAMP_BITS-1:0]  low_t;
        logic [pwm_pdm_pkg::PERIOD_BITS-1:0] period;
        logic [23:0]                         scaled;
        t_pwm_meas                           m;
        track_edge = 1'b0;
        case (exp_phase)
            pwm_pdm_pkg::PH_HIGH: begin
                if (!rising) begin
                    exp_fall = stamp;
                    exp_phase = pwm_pdm_pkg::PH_LOW;
                    track_edge = 1'b1;
                end
            end
            pwm_pdm_pkg::PH_LOW: begin
                if (rising) begin
                    high_t = exp_fall - exp_rise;
                    low_t = stamp - exp_fall;
                    period = {1'b0, high_t} + {1'b0, low_t};
                    m.period = period;
                    m.pulse = high_t;
                    if (period == '0) begin
                        m.duty = '0;
                        m.zero = 1'b1;
                    end else begin
                        scaled = high_t * pwm_pdm_pkg::PCT_SCALE;
                        m.duty = pwm_pdm_pkg::DUTY_BITS'(scaled / period);
                        m.zero = 1'b0;
                    end
                    meas_q.push_back(m);
                    exp_rise = stamp;
                    exp_phase = pwm_pdm_pkg::PH_HIGH;
                    track_edge = 1'b1;
                end
            end
            default: begin
                if (rising) begin
                    exp_rise = stamp;
                    exp_phase = pwm_pdm_pkg::PH_HIGH;
                    track_edge = 1'b1;
                end
            end
        endcase
    endfunction

    task automatic send_edge(input logic [pwm_pdm_pkg::STAMP_BITS-1:0] stamp,
                             input logic rising, output logic effective);
        i_valid <= 1'b1;
        i_edge_stamp <= stamp;
        i_edge_rising <= rising;
        do @(posedge i_clk); while (o_stall);
        effective = track_edge(stamp, rising);
        last_stamp = stamp;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (meas_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed rise/fall/rise sequences, some wrong-polarity noise.
    task automatic random_edges(input int n);
        int                                 done;
        int                                 sel;
        logic [pwm_pdm_pkg::STAMP_BITS-1:0] stamp;
        logic                               rising;
        logic                               eff;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 99) < 85) begin
                rising = (exp_phase != pwm_pdm_pkg::PH_HIGH);
            end else begin
                rising = 1'($urandom_range(0, 1));
            end
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                stamp = last_stamp;
            end else if (sel < 6) begin
                stamp = last_stamp + 16'($urandom_range(1, 300));
            end else begin
                stamp = 16'($urandom);
            end
            send_edge(stamp, rising, eff);
            if (eff) begin
                done++;
            end
        end
    endtask

    // {rising, stamp}: ignored edges in every phase, max period, zero period,
    // 100% and 0% duty, counter wrap in high and in low time.
    task automatic test_directed();
        logic [16:0] items[20] = '{
            {1'b0, 16'h1234}, {1'b1, 16'h0000}, {1'b1, 16'h0000}, {1'b0, 16'hFFFF},
            {1'b0, 16'h0001}, {1'b1, 16'hFFFE}, {1'b0, 16'hFFFE}, {1'b1, 16'hFFFE},
            {1'b0, 16'h0003}, {1'b1, 16'h0003}, {1'b0, 16'h0003}, {1'b1, 16'h8003},
            {1'b0, 16'hFFF0}, {1'b1, 16'h0010}, {1'b0, 16'h0011}, {1'b1, 16'h0012},
            {1'b0, 16'h0013}, {1'b1, 16'h0016}, {1'b0, 16'h5555}, {1'b1, 16'hAAAA}
        };
        logic eff;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        foreach (items[i]) begin
            send_edge(items[i][15:0], items[i][16], eff);
        end
    endtask

    task automatic test_random_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        random_edges(650);
    endtask

    task automatic test_pause_then_resume();
        wait_drained();
        random_edges(650);
    endtask

    task automatic test_random_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_edges(370);
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pwm_meas m;
        if (i_rst_n && o_valid && !i_stall) begin
            if (meas_q.size() == 0) begin
                $error("unexpected result transaction: period_ticks %0d", o_period_ticks);
                fail_cnt++;
            end else begin
                m = meas_q.pop_front();
                if (o_period_ticks !== m.period) begin
                    $error("period_ticks: expected %0d, actual %0d", m.period, o_period_ticks);
                    fail_cnt++;
                end
                if (o_duty_percent !== m.duty) begin
                    $error("duty_percent: expected %0d, actual %0d", m.duty, o_duty_percent);
                    fail_cnt++;
                end
                if (o_pulse_ticks !== m.pulse) begin
                    $error("pulse_ticks: expected %0d, actual %0d", m.pulse, o_pulse_ticks);
                    fail_cnt++;
                end
                if (o_zero_period !== m.zero) begin
                    $error("zero_period: expected %0d, actual %0d", m.zero, o_zero_period);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_edge_stamp = '0;
        i_edge_rising = 1'b0;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        fail_cnt = 0;
        exp_phase = pwm_pdm_pkg::PH_IDLE;
        exp_rise = '0;
        exp_fall = '0;
        last_stamp = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_idle();
        test_pause_then_resume();
        test_random_no_idle();
        wait_drained();
        if (meas_q.size() != 0) begin
            $error("%0d result transactions never arrived", meas_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/pwm_pdm_pkg.sv
design/pwm_pdm_dp.sv
design/pwm_pdm_ctrl.sv
design/pwm_period_duty_measure.sv
dv/tb_pwm_period_duty_measure.sv
